/* hw/rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEFAULT     = 16;
	localparam int KEY_WIDTH_DEFAULT = 16;

	localparam int KEY_PORT_WIDTH    = 16;
	localparam int COUNT_PORT_WIDTH  = 5;
	localparam int STATUS_WIDTH      = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic apply;
	} dp_cmd_t;

endpackage

/* hw/rtl/spq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: takes one command, applies it once the result register is free.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	output logic            res_valid,
	input  logic            res_stall,
	output spq_pkg::dp_cmd_t dp_cmd
);
	import spq_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        res_valid_q, res_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		res_valid_d    = res_valid_q && res_stall;
		dp_cmd.capture = 1'b0;
		dp_cmd.apply   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					dp_cmd.capture = 1'b1;
					state_d        = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the result register is empty or drains this cycle
				if (!res_valid_q || !res_stall) begin
					dp_cmd.apply = 1'b1;
					res_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

endmodule

/* hw/rtl/spq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Row of compare-and-shift cells holding the keys in priority order.
// ----------------------------------------------------------------------------
module spq_datapath #(
	parameter int DEPTH     = spq_pkg::DEPTH_DEFAULT,
	parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  spq_pkg::dp_cmd_t                     dp_cmd,
	input  logic                                 cfg_we,
	input  logic                                 cfg_wdata,
	input  logic                                 command,
	input  logic [spq_pkg::KEY_PORT_WIDTH-1:0]   key,
	output logic [spq_pkg::KEY_PORT_WIDTH-1:0]   head_key,
	output logic [spq_pkg::COUNT_PORT_WIDTH-1:0] entry_count,
	output logic [spq_pkg::STATUS_WIDTH-1:0]     status
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int KP = KEY_PORT_WIDTH;
	localparam int CP = COUNT_PORT_WIDTH;

	logic                    order_select_q;
	logic                    command_q;
	logic [KEY_WIDTH-1:0]    key_q;
	logic [KEY_WIDTH-1:0]    keys_q [DEPTH];
	logic [KEY_WIDTH-1:0]    keys_d [DEPTH];
	logic [KEY_WIDTH-1:0]    ins_val [DEPTH];
	logic [KEY_WIDTH-1:0]    rem_val [DEPTH];
	logic [DEPTH-1:0]        take;
	logic [DEPTH-1:0]        reached;
	logic [CW-1:0]           count_q, count_d;
	logic                    full, empty, ins_ok, rem_ok;
	logic [STATUS_WIDTH-1:0] status_d;
	logic [KEY_WIDTH-1:0]    head_d;
	logic [KEY_WIDTH+KP-1:0] key_wide;
	logic [KEY_WIDTH+KP-1:0] head_wide;
	logic [CW+CP-1:0]        count_wide;
	logic [KP-1:0]           head_key_q;
	logic [CP-1:0]           entry_count_q;
	logic [STATUS_WIDTH-1:0] status_q;

	assign key_wide = {{KEY_WIDTH{1'b0}}, key};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_select_q <= 1'b0;
		end else if (cfg_we) begin
			order_select_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			command_q <= command;
			key_q     <= key_wide[KEY_WIDTH-1:0];
		end
	end

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign ins_ok = (command_q == CMD_INSERT) && !full;
	assign rem_ok = (command_q == CMD_REMOVE) && !empty;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic occupied, outranks;
		assign occupied = (CW'(i) < count_q);
		assign outranks = order_select_q ? (key_q < keys_q[i]) : (key_q > keys_q[i]);
		assign take[i]  = occupied ? outranks : 1'b1;

		if (i == 0) begin : g_first
			assign reached[i] = take[i];
			assign ins_val[i] = reached[i] ? key_q : keys_q[i];
		end else begin : g_rest
			assign reached[i] = reached[i-1] | take[i];
			assign ins_val[i] = !reached[i] ? keys_q[i] :
				(reached[i-1] ? keys_q[i-1] : key_q);
		end

		if (i == DEPTH - 1) begin : g_last
			assign rem_val[i] = keys_q[i];
		end else begin : g_inner
			assign rem_val[i] = keys_q[i+1];
		end

		assign keys_d[i] = ins_ok ? ins_val[i] : (rem_ok ? rem_val[i] : keys_q[i]);
	end

	always_comb begin
		count_d  = count_q;
		status_d = STATUS_DONE;
		if (command_q == CMD_INSERT) begin
			if (full) status_d = STATUS_FULL;
			else      count_d  = count_q + CW'(1);
		end else begin
			if (empty) status_d = STATUS_EMPTY;
			else       count_d  = count_q - CW'(1);
		end
	end

	assign head_d     = (count_d != '0) ? keys_d[0] : '0;
	assign head_wide  = {{KP{1'b0}}, head_d};
	assign count_wide = {{CP{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dp_cmd.apply) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.apply) begin
			for (int i = 0; i < DEPTH; i++) keys_q[i] <= keys_d[i];
			head_key_q    <= head_wide[KP-1:0];
			entry_count_q <= count_wide[CP-1:0];
			status_q      <= status_d;
		end
	end

	assign head_key    = head_key_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;

endmodule

/* hw/rtl/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of up to DEPTH keys kept in sorted order.
// ----------------------------------------------------------------------------
// Command channel (cmd_valid / cmd_stall): command 0 inserts key, command 1
// removes the head. Result channel (res_valid / res_stall): head_key,
// entry_count and status, one result per command. A transfer happens on a
// clock edge with valid high and stall low.
// Each command is first captured into the input register; then, in the execute
// step, every cell compares against the key and shifts in parallel, and the
// result register is loaded. The next command is taken only once the queue is
// back in idle, i.e. after the current command has left the execute step.
// The result register decouples the sides: a command is still taken while a
// result waits; while the receiver stalls, the next command holds in the
// execute step until the result register drains.
// cfg_we/cfg_wdata write order_select; user must write it only while idle (not
// enforced). 0 serves the largest key first, 1 the smallest; equal keys FIFO.
// Reset empties the queue and sets order_select to 0; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int DEPTH     = spq_pkg::DEPTH_DEFAULT,
	parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_wdata,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  logic                                 command,
	input  logic [spq_pkg::KEY_PORT_WIDTH-1:0]   key,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [spq_pkg::KEY_PORT_WIDTH-1:0]   head_key,
	output logic [spq_pkg::COUNT_PORT_WIDTH-1:0] entry_count,
	output logic [spq_pkg::STATUS_WIDTH-1:0]     status
);
	import spq_pkg::*;

	dp_cmd_t dp_cmd;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.dp_cmd    (dp_cmd)
	);

	spq_datapath #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.command     (command),
		.key         (key),
		.head_key    (head_key),
		.entry_count (entry_count),
		.status      (status)
	);

endmodule

/* hw/rtl/spq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue.
// ----------------------------------------------------------------------------
module spq_checker #(
	parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cmd_valid,
	input logic                                 cmd_stall,
	input logic                                 res_valid,
	input logic                                 res_stall,
	input logic [spq_pkg::KEY_PORT_WIDTH-1:0]   head_key,
	input logic [spq_pkg::COUNT_PORT_WIDTH-1:0] entry_count,
	input logic [spq_pkg::STATUS_WIDTH-1:0]     status
);
	import spq_pkg::*;

	localparam bit COUNT_FITS = (DEPTH < (1 << COUNT_PORT_WIDTH));

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while another is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (status == STATUS_DONE) || (status == STATUS_FULL) ||
			(status == STATUS_EMPTY))
		else $error("undefined status code");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == STATUS_EMPTY) |-> (entry_count == '0) && (head_key == '0))
		else $error("remove on empty reports stored keys");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && COUNT_FITS |-> (32'(entry_count) <= 32'(DEPTH)))
		else $error("entry count beyond depth");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_valid),
	.cmd_stall   (cmd_stall),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.head_key    (head_key),
	.entry_count (entry_count),
	.status      (status)
);
